// ----- rtl/ssif_mpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and the result record for the SSIF multi-part read reassembler.
// No dependencies; every other file in rtl/ uses this package.
package ssif_mpr_pkg;

	localparam int BufferBytes = 32;
	localparam int MaxCapacity = 32;
	localparam int ResFifoDepth = 4;

	localparam logic [5:0] CapacityReset = 6'd32;
	localparam logic [7:0] LenMultipart = 8'd30;
	localparam logic [7:0] HdrByte0 = 8'h00;
	localparam logic [7:0] HdrByte1 = 8'h01;
	localparam logic [7:0] LastBlockNum = 8'hFF;
	localparam logic [15:0] TotalMax = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [4:0]  payload_index;
		logic        byte_valid;
		logic        read_next_block;
		logic        message_done;
		logic [15:0] total_bytes;
		logic        last;
	} result_t;

endpackage

// ----- rtl/ssif_mpr_core.sv -----
`timescale 1ns / 1ps
// Reassembly state machine: updates the message state for each accepted byte and
// produces up to two result records. Depends on ssif_mpr_pkg.
module ssif_mpr_core #(
	parameter int BUFFER_BYTES = ssif_mpr_pkg::BufferBytes
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [5:0]            cfg_data,
	input  logic                  in_fire,
	input  logic [7:0]            rx_byte,
	input  logic                  first_of_message,
	output logic [1:0]            push_n,
	output ssif_mpr_pkg::result_t res0,
	output ssif_mpr_pkg::result_t res1
);

	localparam int CapMax = (BUFFER_BYTES < ssif_mpr_pkg::MaxCapacity) ?
		BUFFER_BYTES : ssif_mpr_pkg::MaxCapacity;
	localparam logic [5:0] CapMaxV = 6'(CapMax);

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_HDR  = 6'b000010,
		PH_PAY  = 6'b000100,
		PH_CLEN = 6'b001000,
		PH_CBLK = 6'b010000,
		PH_DONE = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        in_first_q, in_first_d;
	logic        multi_q, multi_d;
	logic        final_q, final_d;
	logic        hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  left_q, left_d;
	logic [5:0]  stored_q, stored_d;
	logic [15:0] total_q, total_d;
	logic [7:0]  held_q, held_d;
	logic [5:0]  cap_q;

	logic [5:0]  eff_cap;
	logic [5:0]  stored_1;
	logic [7:0]  left_1;
	logic        st0, st1, more;
	ssif_mpr_pkg::result_t r0, r1;
	logic [1:0]  n;

	function automatic logic [15:0] sat_add(input logic [15:0] t, input logic [7:0] b);
		logic [16:0] s;
		s = {1'b0, t} + {9'd0, b};
		return s[16] ? ssif_mpr_pkg::TotalMax : s[15:0];
	endfunction

	function automatic ssif_mpr_pkg::result_t byte_res(input logic [7:0] b,
		input logic [5:0] idx);
		ssif_mpr_pkg::result_t r;
		r = '0;
		r.payload_byte = b;
		r.payload_index = idx[4:0];
		r.byte_valid = 1'b1;
		return r;
	endfunction

	// End of block: either ask for the next read or report the finished message.
	function automatic ssif_mpr_pkg::result_t end_res(input logic m, input logic [15:0] t);
		ssif_mpr_pkg::result_t r;
		r = '0;
		r.read_next_block = m;
		r.message_done = !m;
		r.total_bytes = m ? 16'd0 : t;
		return r;
	endfunction

	assign eff_cap = (cap_q > CapMaxV) ? CapMaxV : cap_q;

	always_comb begin
		phase_d = phase_q;
		in_first_d = in_first_q;
		multi_d = multi_q;
		final_d = final_q;
		hdr_cnt_d = hdr_cnt_q;
		left_d = left_q;
		stored_d = stored_q;
		total_d = total_q;
		held_d = held_q;
		r0 = '0;
		r1 = '0;
		n = 2'd0;
		st0 = stored_q < eff_cap;
		stored_1 = stored_q + {5'd0, st0};
		st1 = stored_1 < eff_cap;
		left_1 = left_q - 8'd1;
		more = in_first_q ? multi_q : !final_q;
		if (in_fire) begin
			if (first_of_message) begin
				in_first_d = 1'b1;
				multi_d = 1'b0;
				final_d = 1'b0;
				stored_d = 6'd0;
				total_d = {8'd0, rx_byte};
				hdr_cnt_d = 1'b0;
				left_d = rx_byte;
				if (rx_byte == ssif_mpr_pkg::LenMultipart) begin
					phase_d = PH_HDR;
				end else if (rx_byte == 8'd0) begin
					// An empty single-part message completes at its length byte.
					in_first_d = 1'b0;
					phase_d = PH_DONE;
					r0 = end_res(1'b0, 16'd0);
					n = 2'd1;
				end else begin
					phase_d = PH_PAY;
				end
			end else begin
				case (phase_q)
					PH_HDR: begin
						if (!hdr_cnt_q) begin
							held_d = rx_byte;
							hdr_cnt_d = 1'b1;
						end else begin
							hdr_cnt_d = 1'b0;
							phase_d = PH_PAY;
							if (held_q == ssif_mpr_pkg::HdrByte0 &&
								rx_byte == ssif_mpr_pkg::HdrByte1) begin
								multi_d = 1'b1;
							end else begin
								// Not a multi-part header: both held bytes are payload.
								left_d = left_q - 8'd2;
								stored_d = stored_1 + {5'd0, st1};
								if (st0) begin
									r0 = byte_res(held_q, stored_q);
									r1 = byte_res(rx_byte, stored_1);
								end else begin
									r0 = byte_res(rx_byte, stored_1);
								end
								n = {1'b0, st0} + {1'b0, st1};
							end
						end
					end
					PH_PAY: begin
						left_d = left_1;
						stored_d = stored_1;
						if (st0) begin
							r0 = byte_res(rx_byte, stored_q);
						end
						if (left_1 == 8'd0) begin
							in_first_d = 1'b0;
							phase_d = more ? PH_CLEN : PH_DONE;
							if (st0) begin
								r1 = end_res(more, total_q);
								n = 2'd2;
							end else begin
								r0 = end_res(more, total_q);
								n = 2'd1;
							end
						end else begin
							n = {1'b0, st0};
						end
					end
					PH_CLEN: begin
						left_d = rx_byte;
						total_d = sat_add(total_q, rx_byte);
						phase_d = PH_CBLK;
					end
					PH_CBLK: begin
						final_d = rx_byte == ssif_mpr_pkg::LastBlockNum;
						if (left_q == 8'd0) begin
							in_first_d = 1'b0;
							if (in_first_q ? multi_q :
								rx_byte != ssif_mpr_pkg::LastBlockNum) begin
								phase_d = PH_CLEN;
								r0 = end_res(1'b1, total_q);
							end else begin
								phase_d = PH_DONE;
								r0 = end_res(1'b0, total_q);
							end
							n = 2'd1;
						end else begin
							phase_d = PH_PAY;
						end
					end
					default: begin
					end
				endcase
			end
		end
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end else if (n == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	assign push_n = n;
	assign res0 = r0;
	assign res1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			in_first_q <= 1'b1;
			multi_q <= 1'b0;
			final_q <= 1'b0;
			hdr_cnt_q <= 1'b0;
			left_q <= 8'd0;
			stored_q <= 6'd0;
			total_q <= 16'd0;
			cap_q <= ssif_mpr_pkg::CapacityReset;
		end else begin
			phase_q <= phase_d;
			in_first_q <= in_first_d;
			multi_q <= multi_d;
			final_q <= final_d;
			hdr_cnt_q <= hdr_cnt_d;
			left_q <= left_d;
			stored_q <= stored_d;
			total_q <= total_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
	end

endmodule

// ----- rtl/ssif_mpr_fifo.sv -----
`timescale 1ns / 1ps
// Result queue: takes up to two result records per cycle and hands out one per
// transaction on the output channel. Depends on ssif_mpr_pkg.
module ssif_mpr_fifo #(
	parameter int DEPTH = ssif_mpr_pkg::ResFifoDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            push_n,
	input  ssif_mpr_pkg::result_t din0,
	input  ssif_mpr_pkg::result_t din1,
	output logic                  has_room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ssif_mpr_pkg::result_t dout
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ssif_mpr_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = count_q != '0;
	assign pop = out_valid && out_ready;
	assign dout = mem_q[rd_ptr_q];
	// Room for the largest burst one input byte can cause.
	assign has_room = count_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + AW'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

// ----- rtl/ssif_multipart_read_reassembler.sv -----
`timescale 1ns / 1ps
// Top level of the SSIF multi-part read reassembler.
// Depends on ssif_mpr_pkg, ssif_mpr_core and ssif_mpr_fifo.
//
// Each byte of an SMBus block-read response is accepted and applied
// to the reassembly state at once; the results it causes (at most two: stored
// payload bytes, then a next-read request or a done record with the total)
// go into a four-entry result queue and leave one per output transaction.
// The input accepts a byte whenever the queue has two free entries, so a
// byte that causes no result can follow every cycle, one that causes one
// too while out_ready is high; the output port sets the sustained rate of two-result bytes.
// The capacity register may be written only while no results are pending.
module ssif_multipart_read_reassembler #(
	parameter int BUFFER_BYTES = ssif_mpr_pkg::BufferBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  capacity_limit,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        first_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic [4:0]  payload_index,
	output logic        byte_valid,
	output logic        read_next_block,
	output logic        message_done,
	output logic [15:0] total_bytes,
	output logic        last
);

	logic                  in_fire;
	logic [1:0]            push_n;
	ssif_mpr_pkg::result_t res0, res1, dout;

	assign in_fire = in_valid && in_ready;

	ssif_mpr_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_data        (capacity_limit),
		.in_fire         (in_fire),
		.rx_byte         (rx_byte),
		.first_of_message(first_of_message),
		.push_n          (push_n),
		.res0            (res0),
		.res1            (res1)
	);

	ssif_mpr_fifo #(
		.DEPTH(ssif_mpr_pkg::ResFifoDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.din0     (res0),
		.din1     (res1),
		.has_room (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dout     (dout)
	);

	assign payload_byte = dout.payload_byte;
	assign payload_index = dout.payload_index;
	assign byte_valid = dout.byte_valid;
	assign read_next_block = dout.read_next_block;
	assign message_done = dout.message_done;
	assign total_bytes = dout.total_bytes;
	assign last = dout.last;

endmodule
